FILE: hw/rtl/nct_pkg.sv
// Shared types and constants for the nearest center tracker.
package nct_pkg;

  localparam int unsigned MaxRowsDef  = 4096;
  localparam int unsigned MaxCenters  = 256;
  localparam int unsigned RowW        = 12;
  localparam int unsigned CenterW     = 8;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned SquareW     = 32;
  localparam int unsigned DistW       = 40;
  localparam int unsigned CostW       = 52;
  localparam int unsigned InDataW     = 56;
  localparam int unsigned OutDataW    = 104;
  localparam int unsigned OutUserW    = 2;
  localparam int unsigned FifoDepth   = 8;

  typedef enum logic {
    REQ_CLEAR = 1'b0,
    REQ_DIST  = 1'b1
  } nct_req_e;

  typedef struct packed {
    logic               valid;
    logic               clear;
    logic               last;
    logic               row_ok;
    logic [RowW-1:0]    row;
    logic [CenterW-1:0] center;
  } nct_ctl_t;

  typedef struct packed {
    logic               has;
    logic [CenterW-1:0] center;
    logic [DistW-1:0]   distance;
  } nct_entry_t;

  typedef struct packed {
    logic [CostW-1:0]   total_cost;
    logic               changed;
    logic               has;
    logic [CenterW-1:0] center;
    logic [DistW-1:0]   distance;
  } nct_result_t;

endpackage

FILE: hw/rtl/nct_ram.sv
// Generic simple dual-port RAM with registered read, old data on collision.
module nct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hw/rtl/nct_accum.sv
// Square of the coordinate difference and saturating per-row partial sum.
module nct_accum #(
  parameter int unsigned MAX_ROWS = nct_pkg::MaxRowsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  nct_pkg::nct_req_e                 in_req_i,
  input  logic [nct_pkg::RowW-1:0]          in_row_i,
  input  logic [nct_pkg::CenterW-1:0]       in_center_i,
  input  logic signed [nct_pkg::CoordW-1:0] in_point_i,
  input  logic signed [nct_pkg::CoordW-1:0] in_center_coord_i,
  input  logic                              in_last_i,
  output nct_pkg::nct_ctl_t                 s1_ctl_o,
  output nct_pkg::nct_ctl_t                 s2_ctl_o,
  output logic [nct_pkg::DistW-1:0]         s2_dist_o
);

  import nct_pkg::*;

  logic [CoordW:0]   diff;
  logic [CoordW-1:0] abs_diff;
  logic [SquareW-1:0] sq_d, sq_q;
  nct_ctl_t          s1_ctl_d, s1_ctl_q, s2_ctl_q;
  logic [DistW:0]    sum;
  logic [DistW-1:0]  sat_sum;
  logic [DistW-1:0]  partial_d, partial_q, s2_dist_q;

  always_comb begin
    diff     = {in_point_i[CoordW-1], in_point_i}
             - {in_center_coord_i[CoordW-1], in_center_coord_i};
    abs_diff = diff[CoordW] ? CoordW'(-diff) : diff[CoordW-1:0];
    sq_d     = abs_diff * abs_diff;

    s1_ctl_d.valid  = in_valid_i;
    s1_ctl_d.clear  = (in_req_i == REQ_CLEAR);
    s1_ctl_d.last   = in_last_i;
    s1_ctl_d.row_ok = (32'(in_row_i) < MAX_ROWS);
    s1_ctl_d.row    = in_row_i;
    s1_ctl_d.center = in_center_i;
  end

  always_comb begin
    sum       = {1'b0, partial_q} + (DistW+1)'(sq_q);
    sat_sum   = sum[DistW] ? '1 : sum[DistW-1:0];
    partial_d = partial_q;
    if (s1_ctl_q.valid && !s1_ctl_q.clear) begin
      partial_d = s1_ctl_q.last ? '0 : sat_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q  <= '0;
      s2_ctl_q  <= '0;
      partial_q <= '0;
    end else begin
      s1_ctl_q  <= s1_ctl_d;
      s2_ctl_q  <= s1_ctl_q;
      partial_q <= partial_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q      <= sq_d;
    s2_dist_q <= sat_sum;
  end

  assign s1_ctl_o  = s1_ctl_q;
  assign s2_ctl_o  = s2_ctl_q;
  assign s2_dist_o = s2_dist_q;

endmodule

FILE: hw/rtl/nct_update.sv
// Row entry forwarding, closest-center compare, write back and cost total.
module nct_update (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nct_pkg::nct_ctl_t           s1_ctl_i,
  input  nct_pkg::nct_entry_t         rd_entry_i,
  input  nct_pkg::nct_ctl_t           s2_ctl_i,
  input  logic [nct_pkg::DistW-1:0]   s2_dist_i,
  output logic                        wr_en_o,
  output logic [nct_pkg::RowW-1:0]    wr_row_o,
  output nct_pkg::nct_entry_t         wr_entry_o,
  output logic                        res_valid_o,
  output nct_pkg::nct_result_t        res_o
);

  import nct_pkg::*;

  nct_entry_t       fwd_entry, entry_q, new_entry;
  logic             lw_valid_q;
  logic [RowW-1:0]  lw_row_q;
  nct_entry_t       lw_entry_q;
  logic             s2_result, center_ok, take;
  logic [DistW-1:0] sub_d, add_d;
  logic             s3_valid_q, s3_changed_q;
  nct_entry_t       s3_entry_q;
  logic [DistW-1:0] s3_sub_q, s3_add_q;
  logic [CostW-1:0] cost_d, cost_q;

  // Bring the S1 view up to date with writes the RAM read did not see.
  always_comb begin
    fwd_entry = rd_entry_i;
    if (lw_valid_q && lw_row_q == s1_ctl_i.row) begin
      fwd_entry = lw_entry_q;
    end
    if (wr_en_o && wr_row_o == s1_ctl_i.row) begin
      fwd_entry = wr_entry_o;
    end
  end

  always_comb begin
    s2_result = s2_ctl_i.valid && s2_ctl_i.row_ok && (s2_ctl_i.clear || s2_ctl_i.last);
    center_ok = (32'(s2_ctl_i.center) < MaxCenters);
    take      = !s2_ctl_i.clear && center_ok
             && (!entry_q.has || s2_dist_i < entry_q.distance);
    new_entry = entry_q;
    if (s2_ctl_i.clear) begin
      new_entry.has = 1'b0;
    end else if (take) begin
      new_entry.has      = 1'b1;
      new_entry.center   = s2_ctl_i.center;
      new_entry.distance = s2_dist_i;
    end
    sub_d = (entry_q.has && (s2_ctl_i.clear || take)) ? entry_q.distance : '0;
    add_d = take ? s2_dist_i : '0;
  end

  assign wr_en_o    = s2_result;
  assign wr_row_o   = s2_ctl_i.row;
  assign wr_entry_o = new_entry;

  always_comb begin
    cost_d = cost_q - CostW'(s3_sub_q) + CostW'(s3_add_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      cost_q     <= '0;
    end else begin
      lw_valid_q <= wr_en_o;
      s3_valid_q <= s2_result;
      if (s3_valid_q) begin
        cost_q <= cost_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q      <= fwd_entry;
    lw_row_q     <= wr_row_o;
    lw_entry_q   <= wr_entry_o;
    s3_entry_q   <= new_entry;
    s3_changed_q <= take;
    s3_sub_q     <= sub_d;
    s3_add_q     <= add_d;
  end

  always_comb begin
    res_o.total_cost = cost_d;
    res_o.changed    = s3_changed_q;
    res_o.has        = s3_entry_q.has;
    res_o.center     = s3_entry_q.has ? s3_entry_q.center : '0;
    res_o.distance   = s3_entry_q.has ? s3_entry_q.distance : '0;
  end

  assign res_valid_o = s3_valid_q;

endmodule

FILE: hw/rtl/nct_fifo.sv
// Output word queue that decouples the pipeline from the result stream.
module nct_fifo (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  nct_pkg::nct_result_t                 push_data_i,
  input  logic                                 pop_i,
  output logic                                 valid_o,
  output nct_pkg::nct_result_t                 data_o,
  output logic [$clog2(nct_pkg::FifoDepth+1)-1:0] count_o
);

  import nct_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  nct_result_t     slot_q [FifoDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rptr_q];
  assign count_o = count_q;

endmodule

FILE: hw/rtl/nearest_center_tracker.sv
// Nearest center tracker top level: stream ports, row memory and clearing pass.
// Each input word is one coordinate pair of a row and a candidate center, or a clear of a row.
// The block takes one word per clock while s_axis_tready_o is high, which it drops when the
// output queue could fill. A clear word and a last-dimension word for a row below MAX_ROWS
// each return one word; other words return nothing. The rate is set by the row memory, which
// does one read and one write per cycle, with forwarding from the two writes still in flight.
// A clearing pass after reset sweeps its entries (at most 4096) with s_axis_tready_o held low.
module nearest_center_tracker #(
  parameter int unsigned MAX_ROWS = nct_pkg::MaxRowsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // row_index, center_index, point_coord, center_coord, zero pad
  input  logic [nct_pkg::InDataW-1:0]   s_axis_tdata_i,
  // req_type
  input  logic                          s_axis_tuser_i,
  // last_dim
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // row_distance, row_center, total_cost, zero pad
  output logic [nct_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // row_has_center, changed
  output logic [nct_pkg::OutUserW-1:0]  m_axis_tuser_o
);

  import nct_pkg::*;

  localparam int unsigned Depth = (MAX_ROWS < (1 << RowW)) ? MAX_ROWS : (1 << RowW);
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(FifoDepth + 1);

  logic             accept;
  nct_req_e         in_req;
  nct_ctl_t         s1_ctl, s2_ctl;
  logic [DistW-1:0] s2_dist;
  nct_entry_t       rd_entry, wr_entry;
  logic             wr_en;
  logic [RowW-1:0]  wr_row;
  logic             res_valid;
  nct_result_t      res, head;
  logic [CntW-1:0]  fifo_count;
  logic [CntW:0]    reserved;
  logic             clr_active_q;
  logic [AddrW-1:0] clr_cnt_q;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  nct_entry_t       ram_wdata;

  assign in_req   = nct_req_e'(s_axis_tuser_i);
  assign reserved = (CntW+1)'(fifo_count) + (CntW+1)'(s1_ctl.valid)
                  + (CntW+1)'(s2_ctl.valid) + (CntW+1)'(res_valid);
  assign s_axis_tready_o = !clr_active_q && (reserved < (CntW+1)'(FifoDepth));
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Sweep the row memory once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AddrW'(Depth - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  always_comb begin
    ram_we    = wr_en;
    ram_waddr = wr_row[AddrW-1:0];
    ram_wdata = wr_entry;
    if (clr_active_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end
  end

  nct_accum #(
    .MAX_ROWS (MAX_ROWS)
  ) u_accum (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (accept),
    .in_req_i          (in_req),
    .in_row_i          (s_axis_tdata_i[11:0]),
    .in_center_i       (s_axis_tdata_i[19:12]),
    .in_point_i        (s_axis_tdata_i[35:20]),
    .in_center_coord_i (s_axis_tdata_i[51:36]),
    .in_last_i         (s_axis_tlast_i),
    .s1_ctl_o          (s1_ctl),
    .s2_ctl_o          (s2_ctl),
    .s2_dist_o         (s2_dist)
  );

  nct_ram #(
    .Width ($bits(nct_entry_t)),
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (s_axis_tdata_i[AddrW-1:0]),
    .rdata_o (rd_entry)
  );

  nct_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_ctl_i    (s1_ctl),
    .rd_entry_i  (rd_entry),
    .s2_ctl_i    (s2_ctl),
    .s2_dist_i   (s2_dist),
    .wr_en_o     (wr_en),
    .wr_row_o    (wr_row),
    .wr_entry_o  (wr_entry),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  nct_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (m_axis_tready_i),
    .valid_o     (m_axis_tvalid_o),
    .data_o      (head),
    .count_o     (fifo_count)
  );

  assign m_axis_tdata_o = {4'b0, head.total_cost, head.center, head.distance};
  assign m_axis_tuser_o = {head.changed, head.has};

endmodule

FILE: sim/nct_result_checker.sv
// Result checker for the nearest center tracker: tracks row entries and compares output words.
module nct_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [nct_pkg::InDataW-1:0]   in_data_i,
  input  logic                          in_user_i,
  input  logic                          in_last_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [nct_pkg::OutDataW-1:0]  out_data_i,
  input  logic [nct_pkg::OutUserW-1:0]  out_user_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   reports_pending_o
);
  import nct_pkg::*;

  logic [DistW-1:0]    row_dist [MaxRowsDef];
  logic [CenterW-1:0]  row_ctr [MaxRowsDef];
  bit                  row_has [MaxRowsDef];
  logic [DistW-1:0]    partial_sum;
  logic [CostW-1:0]    cost_sum;
  nct_result_t         row_reports_q [$];
  nct_result_t         want;
  nct_result_t         got;
  int unsigned         mismatches;
  logic [RowW-1:0]     row;
  logic [CenterW-1:0]  ctr;
  logic [CoordW-1:0]   pc;
  logic [CoordW-1:0]   cc;
  logic signed [16:0]  diff;
  logic [16:0]         mag;
  logic [DistW:0]      sum;
  logic [DistW-1:0]    new_dist;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxRowsDef; i++) begin
        row_has[i] = 1'b0;
      end
      partial_sum = '0;
      cost_sum    = '0;
      mismatches  = 0;
      row_reports_q.delete();
      reports_pending_o <= 0;
      mismatch_count_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.distance   = out_data_i[DistW-1:0];
        got.center     = out_data_i[DistW+CenterW-1:DistW];
        got.total_cost = out_data_i[DistW+CenterW+CostW-1:DistW+CenterW];
        got.has        = out_user_i[0];
        got.changed    = out_user_i[1];
        if (row_reports_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected output word: dist %h center %0d has %0b changed %0b cost %h",
                     got.distance, got.center, got.has, got.changed, got.total_cost);
          end
        end else begin
          want = row_reports_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected dist %h center %0d has %0b changed %0b cost %h",
                       want.distance, want.center, want.has, want.changed, want.total_cost);
              $display("          got      dist %h center %0d has %0b changed %0b cost %h",
                       got.distance, got.center, got.has, got.changed, got.total_cost);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        row = in_data_i[RowW-1:0];
        ctr = in_data_i[RowW+CenterW-1:RowW];
        pc  = in_data_i[RowW+CenterW+CoordW-1:RowW+CenterW];
        cc  = in_data_i[RowW+CenterW+2*CoordW-1:RowW+CenterW+CoordW];
        if (in_user_i == REQ_CLEAR) begin
          if (row_has[row]) begin
            cost_sum = cost_sum - row_dist[row];
          end
          row_has[row]    = 1'b0;
          want            = '0;
          want.total_cost = cost_sum;
          row_reports_q.push_back(want);
        end else begin
          diff     = $signed({pc[CoordW-1], pc}) - $signed({cc[CoordW-1], cc});
          mag      = diff[16] ? -diff : diff;
          sum      = partial_sum + mag * mag;
          new_dist = sum[DistW] ? '1 : sum[DistW-1:0];
          if (!in_last_i) begin
            partial_sum = new_dist;
          end else begin
            partial_sum  = '0;
            want         = '0;
            want.changed = !row_has[row] || (new_dist < row_dist[row]);
            if (want.changed) begin
              if (row_has[row]) begin
                cost_sum = cost_sum - row_dist[row];
              end
              cost_sum      = cost_sum + new_dist;
              row_dist[row] = new_dist;
              row_ctr[row]  = ctr;
              row_has[row]  = 1'b1;
            end
            want.distance   = row_dist[row];
            want.center     = row_ctr[row];
            want.has        = 1'b1;
            want.total_cost = cost_sum;
            row_reports_q.push_back(want);
          end
        end
      end
      reports_pending_o <= row_reports_q.size();
      mismatch_count_o  <= mismatches;
    end
  end

endmodule

FILE: sim/testbench.sv
// Testbench top for the nearest center tracker: clock, reset, stimulus, back-pressure and verdict.
module testbench;
  import nct_pkg::*;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [InDataW-1:0]    s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OutDataW-1:0]   m_tdata;
  logic [OutUserW-1:0]   m_tuser;
  int unsigned           mismatch_count;
  int unsigned           reports_pending;
  bit                    tx_idle = 1'b1;
  bit                    rx_idle = 1'b1;
  int unsigned           rx_hold = 0;
  int unsigned           words_sent = 0;
  logic [CoordW-1:0]     run_p [$];
  logic [CoordW-1:0]     run_c [$];
  logic [RowW-1:0]       last_row = '0;

  always #5 clk = ~clk;

  nearest_center_tracker DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  nct_result_checker u_result_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (s_tvalid),
    .in_ready_i        (s_tready),
    .in_data_i         (s_tdata),
    .in_user_i         (s_tuser),
    .in_last_i         (s_tlast),
    .out_valid_i       (m_tvalid),
    .out_ready_i       (m_tready),
    .out_data_i        (m_tdata),
    .out_user_i        (m_tuser),
    .mismatch_count_o  (mismatch_count),
    .reports_pending_o (reports_pending)
  );

  task automatic push_word(input nct_req_e req, input logic [RowW-1:0] row,
                           input logic [CenterW-1:0] ctr, input logic [CoordW-1:0] pc,
                           input logic [CoordW-1:0] cc, input logic last);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, cc, pc, ctr, row};
    s_tuser  <= req;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_clear(input logic [RowW-1:0] row);
    push_word(REQ_CLEAR, row, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  function automatic logic [RowW-1:0] pick_row();
    return ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
  endfunction

  function automatic logic [CoordW-1:0] pick_coord(input int mode);
    logic [CoordW-1:0] v;
    case (mode)
      0: v = 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'h0000;
          default: v = 16'hffff;
        endcase
      end
      2: v = 16'($urandom_range(0, 511)) - 16'd256;
      default: v = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    endcase
    return v;
  endfunction

  // Mode 3 pairs opposite extremes so every dimension adds the largest square.
  task automatic send_run(input logic [RowW-1:0] row, input logic [CenterW-1:0] ctr,
                          input int dims, input int mode, input bit replay);
    logic [CoordW-1:0] p;
    if (!replay || run_p.size() == 0) begin
      run_p.delete();
      run_c.delete();
      for (int i = 0; i < dims; i++) begin
        p = pick_coord(mode);
        run_p.push_back(p);
        run_c.push_back((mode == 3) ? ~p : pick_coord(mode));
      end
    end
    foreach (run_p[i]) begin
      if ($urandom_range(0, 40) == 0) begin
        send_clear(pick_row());
      end
      push_word(REQ_DIST, row, ctr, run_p[i], run_c[i], i == run_p.size() - 1);
    end
    last_row = row;
  endtask

  initial begin
    forever begin
      if (rx_hold != 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    bit held;
    bit paused;
    bit long_done;
    int pick;
    held      = 1'b0;
    paused    = 1'b0;
    long_done = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_clear(12'd0);
    push_word(REQ_DIST, 12'd0, 8'd0, 16'h8000, 16'h7fff, 1'b1);
    push_word(REQ_DIST, 12'd0, 8'd255, 16'h7fff, 16'h7fff, 1'b1);
    push_word(REQ_DIST, 12'd0, 8'd1, 16'hffff, 16'hffff, 1'b1);
    push_word(REQ_DIST, 12'd4095, 8'd3, 16'h7fff, 16'h8000, 1'b0);
    push_word(REQ_DIST, 12'd4095, 8'd3, 16'hff00, 16'h0100, 1'b1);
    push_word(REQ_DIST, 12'd4095, 8'd7, 16'h7fff, 16'h8000, 1'b0);
    push_word(REQ_DIST, 12'd4095, 8'd7, 16'hff00, 16'h0100, 1'b1);
    push_word(REQ_DIST, 12'd4095, 8'd9, 16'h0000, 16'h0001, 1'b1);
    send_clear(12'd4095);
    send_clear(12'd4095);
    push_word(REQ_DIST, 12'd5, 8'd2, 16'h0100, 16'h0000, 1'b0);
    send_clear(12'd0);
    push_word(REQ_DIST, 12'd5, 8'd2, 16'hfe00, 16'h0200, 1'b0);
    push_word(REQ_DIST, 12'd5, 8'd2, 16'h0003, 16'hfffd, 1'b1);
    push_word(REQ_DIST, 12'd5, 8'd4, 16'h7fff, 16'h8000, 1'b1);
    push_word(REQ_DIST, 12'd5, 8'd6, 16'h0000, 16'h0000, 1'b1);

    while (words_sent < 2000) begin
      if (!held && words_sent > 500) begin
        held    = 1'b1;
        rx_hold = 300;
        for (int i = 0; i < 24; i++) begin
          send_run(pick_row(), 8'($urandom), 1, 0, 1'b0);
        end
      end
      if (!paused && words_sent > 1000) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_pending != 0) @(posedge clk);
      end
      if (!long_done && words_sent > 800) begin
        long_done = 1'b1;
        send_run(pick_row(), 8'($urandom), 280, 3, 1'b0);
        send_run(last_row, 8'($urandom), 0, 3, 1'b1);
      end
      if (words_sent > 1700) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_clear(pick_row());
      end else if (pick < 20) begin
        send_run(last_row, 8'($urandom), 0, 0, 1'b1);
      end else if (pick < 25) begin
        push_word(nct_req_e'($urandom_range(0, 1)), pick_row(), 8'($urandom),
                  16'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        send_run(pick_row(), 8'($urandom), $urandom_range(1, 8), $urandom_range(0, 2), 1'b0);
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
